// ----- rtl/sbe_pkg.sv -----
`default_nettype none
package sbe_pkg;

  localparam int DEF_OPERAND_DEPTH = 256;
  localparam int DEF_RETURN_DEPTH  = 64;
  localparam int DEF_MEM_WORDS     = 1024;

  localparam int IN_W  = 48;
  localparam int OUT_W = 80;

  localparam logic [7:0] OP_PUSH  = 8'h01;
  localparam logic [7:0] OP_POP   = 8'h02;
  localparam logic [7:0] OP_DUP   = 8'h03;
  localparam logic [7:0] OP_ADD   = 8'h10;
  localparam logic [7:0] OP_SUB   = 8'h11;
  localparam logic [7:0] OP_MUL   = 8'h12;
  localparam logic [7:0] OP_DIV   = 8'h13;
  localparam logic [7:0] OP_CMP   = 8'h14;
  localparam logic [7:0] OP_JMP   = 8'h20;
  localparam logic [7:0] OP_JZ    = 8'h21;
  localparam logic [7:0] OP_JNZ   = 8'h22;
  localparam logic [7:0] OP_STORE = 8'h30;
  localparam logic [7:0] OP_LOAD  = 8'h31;
  localparam logic [7:0] OP_CALL  = 8'h40;
  localparam logic [7:0] OP_RET   = 8'h41;
  localparam logic [7:0] OP_HALT  = 8'hFF;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_UNDER       = 4'd1,
    ERR_DIV0        = 4'd2,
    ERR_JUMP        = 4'd3,
    ERR_INDEX       = 4'd4,
    ERR_RET         = 4'd5,
    ERR_OPCODE      = 4'd6,
    ERR_OVF_OPERAND = 4'd7,
    ERR_OVF_RETURN  = 4'd8
  } err_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_COMMIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clr;
    logic read;
    logic exec;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_go;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/sbe_div.sv -----
`default_nettype none
module sbe_div import sbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  // Restoring division on magnitudes, one quotient bit per cycle.
  logic [31:0] rem_r, q_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r, neg_r;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_r <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r <= dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - q_r) : q_r;
endmodule
`default_nettype wire

// ----- rtl/sbe_ctrl.sv -----
`default_nettype none
module sbe_ctrl import sbe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = sts.div_go ? ST_DIV : ST_COMMIT;
      ST_DIV:    if (sts.div_done) state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_READ:   cmd.read = 1'b1;
      ST_EXEC:   cmd.exec = 1'b1;
      ST_DIV:    cmd = '0;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_OUT:    cmd.load_out = sts.out_free;
      default:   cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/sbe_dpath.sv -----
`default_nettype none
module sbe_dpath import sbe_pkg::*; #(
  parameter int OPERAND_DEPTH = DEF_OPERAND_DEPTH,
  parameter int RETURN_DEPTH  = DEF_RETURN_DEPTH,
  parameter int MEM_WORDS     = DEF_MEM_WORDS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             cfg_we,
  input  wire logic [31:0]      cfg_wdata,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output logic [OUT_W-1:0]      out_tdata
);
  localparam int OW  = $clog2(OPERAND_DEPTH);
  localparam int SPW = $clog2(OPERAND_DEPTH + 1);
  localparam int RW  = $clog2(RETURN_DEPTH);
  localparam int RPW = $clog2(RETURN_DEPTH + 1);
  localparam int AW  = $clog2(MEM_WORDS);

  // Architectural state.
  logic [31:0]    pc_r, len_r, tos_r;
  logic [SPW-1:0] sp_r;
  logic [RPW-1:0] rp_r;
  logic           run_r;
  err_t           err_r;
  logic [AW-1:0]  clr_cnt_r;

  // Item capture.
  logic [7:0]  op_r;
  logic [31:0] imm_r;
  logic        cmpl_r, go_r;

  logic [31:0] opnd_mem [OPERAND_DEPTH];
  logic [31:0] ret_mem  [RETURN_DEPTH];
  logic [31:0] dmem     [MEM_WORDS];
  logic [31:0] a_q_r, dm_q_r, rs_q_r;

  // Decided results, held between execute and commit.
  err_t           x_err_r;
  logic           x_ok_r, x_stop_r;
  logic [31:0]    x_npc_r, x_top_r;
  logic [SPW-1:0] x_sp_r;
  logic [RPW-1:0] x_rp_r;
  logic           ow_en_r, dw_en_r, rw_en_r;
  logic [OW-1:0]  ow_addr_r;
  logic [31:0]    ow_data_r, dw_data_r, rw_data_r;
  logic [AW-1:0]  dw_addr_r;
  logic [RW-1:0]  rw_addr_r;

  logic           out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  err_t           err_nxt;
  logic           halt_nxt, ow_en_nxt, dw_en_nxt, rw_en_nxt, div_go;
  logic [31:0]    npc_nxt, top_nxt, ow_data_nxt, alu;
  logic [SPW-1:0] sp_nxt, sp_m1, sp_m2;
  logic [RPW-1:0] rp_nxt, rp_m1;
  logic [OW-1:0]  ow_addr_nxt;
  logic [31:0]    after_op, after_imm;
  logic           idx_bad;
  logic [31:0]    div_q;
  logic           div_done;

  assign sp_m1     = sp_r - SPW'(1);
  assign sp_m2     = sp_r - SPW'(2);
  assign rp_m1     = rp_r - RPW'(1);
  assign after_op  = pc_r + 32'd1;
  assign after_imm = after_op + (cmpl_r ? 32'd4 : 32'd0);
  assign idx_bad   = imm_r >= 32'(MEM_WORDS);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_tdata[7:0];
      imm_r  <= in_tdata[40] ? in_tdata[39:8] : 32'd0;
      cmpl_r <= in_tdata[40];
      go_r   <= run_r && (pc_r < len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ow_en_r && cmd.commit) opnd_mem[ow_addr_r] <= ow_data_r;
    if (cmd.read) a_q_r <= opnd_mem[sp_m2[OW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rw_en_r && cmd.commit) ret_mem[rw_addr_r] <= rw_data_r;
    if (cmd.read) rs_q_r <= ret_mem[rp_m1[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) dmem[clr_cnt_r] <= 32'd0;
    else if (dw_en_r && cmd.commit) dmem[dw_addr_r] <= dw_data_r;
    if (cmd.read) dm_q_r <= dmem[imm_r[AW-1:0]];
  end

  always_comb begin
    err_nxt     = ERR_NONE;
    halt_nxt    = 1'b0;
    npc_nxt     = after_op;
    sp_nxt      = sp_r;
    rp_nxt      = rp_r;
    top_nxt     = tos_r;
    ow_en_nxt   = 1'b0;
    ow_addr_nxt = sp_r[OW-1:0];
    ow_data_nxt = imm_r;
    dw_en_nxt   = 1'b0;
    rw_en_nxt   = 1'b0;
    alu         = a_q_r + tos_r;
    case (op_r)
      OP_SUB:  alu = a_q_r - tos_r;
      OP_MUL:  alu = a_q_r * tos_r;
      OP_CMP:  alu = ($signed(a_q_r) < $signed(tos_r)) ? 32'hFFFF_FFFF :
                     (($signed(a_q_r) > $signed(tos_r)) ? 32'd1 : 32'd0);
      default: alu = a_q_r + tos_r;
    endcase
    unique case (op_r) inside
      OP_PUSH: begin
        npc_nxt = after_imm;
        if (sp_r == SPW'(OPERAND_DEPTH)) err_nxt = ERR_OVF_OPERAND;
        else begin
          ow_en_nxt = 1'b1;
          sp_nxt    = sp_r + SPW'(1);
          top_nxt   = imm_r;
        end
      end
      OP_POP: begin
        if (sp_r == '0) err_nxt = ERR_UNDER;
        else begin
          sp_nxt  = sp_m1;
          top_nxt = a_q_r;
        end
      end
      OP_DUP: begin
        if (sp_r == '0) err_nxt = ERR_UNDER;
        else if (sp_r == SPW'(OPERAND_DEPTH)) err_nxt = ERR_OVF_OPERAND;
        else begin
          ow_en_nxt   = 1'b1;
          ow_data_nxt = tos_r;
          sp_nxt      = sp_r + SPW'(1);
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
        if (sp_r < SPW'(2)) err_nxt = ERR_UNDER;
        else if (op_r == OP_DIV && tos_r == 32'd0) err_nxt = ERR_DIV0;
        else begin
          ow_en_nxt   = 1'b1;
          ow_addr_nxt = sp_m2[OW-1:0];
          ow_data_nxt = alu;
          sp_nxt      = sp_m1;
          top_nxt     = alu;
        end
      end
      OP_JMP: begin
        if (imm_r >= len_r) err_nxt = ERR_JUMP;
        else npc_nxt = imm_r;
      end
      OP_JZ, OP_JNZ: begin
        if (sp_r == '0) err_nxt = ERR_UNDER;
        else begin
          sp_nxt  = sp_m1;
          top_nxt = a_q_r;
          npc_nxt = ((tos_r == 32'd0) == (op_r == OP_JZ)) ? imm_r : after_imm;
        end
      end
      OP_STORE: begin
        npc_nxt = after_imm;
        if (idx_bad) err_nxt = ERR_INDEX;
        else if (sp_r == '0) err_nxt = ERR_UNDER;
        else begin
          dw_en_nxt = 1'b1;
          sp_nxt    = sp_m1;
          top_nxt   = a_q_r;
        end
      end
      OP_LOAD: begin
        npc_nxt = after_imm;
        if (idx_bad) err_nxt = ERR_INDEX;
        else if (sp_r == SPW'(OPERAND_DEPTH)) err_nxt = ERR_OVF_OPERAND;
        else begin
          ow_en_nxt   = 1'b1;
          ow_data_nxt = dm_q_r;
          sp_nxt      = sp_r + SPW'(1);
          top_nxt     = dm_q_r;
        end
      end
      OP_CALL: begin
        if (imm_r >= len_r) err_nxt = ERR_JUMP;
        else if (rp_r == RPW'(RETURN_DEPTH)) err_nxt = ERR_OVF_RETURN;
        else begin
          rw_en_nxt = 1'b1;
          rp_nxt    = rp_r + RPW'(1);
          npc_nxt   = imm_r;
        end
      end
      OP_RET: begin
        if (rp_r == '0) err_nxt = ERR_RET;
        else begin
          rp_nxt  = rp_m1;
          npc_nxt = rs_q_r;
        end
      end
      OP_HALT: halt_nxt = 1'b1;
      default: err_nxt = ERR_OPCODE;
    endcase
  end

  assign div_go = go_r && (op_r == OP_DIV) && (err_nxt == ERR_NONE);

  sbe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && div_go),
    .dividend (a_q_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      x_err_r   <= go_r ? err_nxt : ERR_NONE;
      x_ok_r    <= go_r && (err_nxt == ERR_NONE);
      x_stop_r  <= go_r && (halt_nxt || (err_nxt != ERR_NONE));
      x_npc_r   <= npc_nxt;
      x_top_r   <= top_nxt;
      x_sp_r    <= sp_nxt;
      x_rp_r    <= rp_nxt;
      ow_en_r   <= go_r && (err_nxt == ERR_NONE) && ow_en_nxt;
      ow_addr_r <= ow_addr_nxt;
      ow_data_r <= ow_data_nxt;
      dw_en_r   <= go_r && (err_nxt == ERR_NONE) && dw_en_nxt;
      dw_addr_r <= imm_r[AW-1:0];
      dw_data_r <= tos_r;
      rw_en_r   <= go_r && (err_nxt == ERR_NONE) && rw_en_nxt;
      rw_addr_r <= rp_r[RW-1:0];
      rw_data_r <= after_imm;
    end else if (div_done) begin
      x_top_r   <= div_q;
      ow_data_r <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      sp_r      <= '0;
      rp_r      <= '0;
      run_r     <= 1'b1;
      len_r     <= '0;
      err_r     <= ERR_NONE;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (cmd.clr) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.commit) begin
        err_r <= x_err_r;
        if (x_ok_r) begin
          pc_r  <= x_npc_r;
          sp_r  <= x_sp_r;
          rp_r  <= x_rp_r;
          tos_r <= x_top_r;
        end
        if (x_stop_r) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out)
      out_data_r <= {1'b0, 9'(sp_r), (sp_r != '0),
                     ((sp_r != '0) ? tos_r : 32'd0), err_r,
                     (!run_r || !(pc_r < len_r)), pc_r};
  end

  assign sts.clr_last = clr_cnt_r == AW'(MEM_WORDS - 1);
  assign sts.div_go   = div_go;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
endmodule
`default_nettype wire

// ----- rtl/stack_bytecode_executor_unit.sv -----
// Sequence: each item passes capture, memory read, execute, commit and output load;
//   DIV adds a divide step on its bit-serial divider (one bit a cycle).
// Items: a new item is accepted only after the previous result has been loaded into
//   the output register; a held result delays the next item.
// Reset: synchronous, active low; afterwards the data memory is cleared one word
//   a cycle over all MEM_WORDS words, during which no item is accepted.
`default_nettype none
module stack_bytecode_executor_unit import sbe_pkg::*; #(
  parameter int OPERAND_DEPTH = DEF_OPERAND_DEPTH,
  parameter int RETURN_DEPTH  = DEF_RETURN_DEPTH,
  parameter int MEM_WORDS     = DEF_MEM_WORDS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // op[7:0], immediate[39:8], imm_complete[40], zero fill[47:41]
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // next_pc[31:0], halted[32], error_code[36:33], top_value[68:37],
  // top_valid[69], stack_depth[78:70], zero fill[79]
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [31:0]      cfg_wdata
);
  // The controller steps each item through capture, memory read, execute,
  // an optional divide, commit and output load. The datapath holds the
  // stacks, the data memory and the program counter, and reports back only
  // the few status bits that steer the sequence.
  cmd_t cmd;
  sts_t sts;

  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The output register lets the controller take a new item while the
  // previous result still waits for the consumer.
  sbe_dpath #(
    .OPERAND_DEPTH (OPERAND_DEPTH),
    .RETURN_DEPTH  (RETURN_DEPTH),
    .MEM_WORDS     (MEM_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

// ----- rtl/sbe_checker.sv -----
`default_nettype none
module sbe_checker import sbe_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);
  // One item at a time: no second item right after an accepted one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted on consecutive cycles");

  // A result that waits keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Any error code comes with a halted block.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[36:33] != 4'd0)) |-> out_tdata[32])
    else $error("error reported without halt");

  // No result right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule

bind stack_bytecode_executor_unit sbe_checker u_sbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
